### rtl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/uvt_pkg.sv
package uvt_pkg;

  localparam int COORD_W   = 32;
  localparam int CFG_W     = 32;
  localparam int CFG_IDX_W = 3;
  localparam int WRAP_W    = 2;
  localparam int PIPE_DEPTH = 4;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_COEF_UU   = 3'd0,
    REG_COEF_UV   = 3'd1,
    REG_COEF_VU   = 3'd2,
    REG_COEF_VV   = 3'd3,
    REG_OFFSET_U  = 3'd4,
    REG_OFFSET_V  = 3'd5,
    REG_WRAP_MODE = 3'd6
  } cfg_reg_t;

  typedef enum logic [WRAP_W-1:0] {
    WRAP_REPEAT = 2'd0,
    WRAP_MIRROR = 2'd1,
    WRAP_CLAMP  = 2'd2
  } wrap_mode_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] coef_a;
    logic signed [COORD_W-1:0] coef_b;
    logic signed [COORD_W-1:0] offset;
  } axis_cfg_t;

endpackage

### rtl/uv_transform_wrap.sv
// Channel   Ports                                 Transfer
// request   start, busy, in_coord_u, in_coord_v   start high and busy low at a clock edge
// result    out_valid, out_wrapped_u/v            out_valid high for one cycle, no stall
// config    cfg_we, cfg_index, cfg_wdata          cfg_we high at a clock edge
//
// A request is taken in every cycle; busy is never raised.
// Each result passes through the input register, multiplier register,
// three-term sum register and wrap/round output register.
// Reset (rst_n low, synchronous) clears the valid pipeline and loads the
// register defaults: identity matrix, offsets of one half, repeat mode.
module uv_transform_wrap #(
  parameter int FRAC_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic [uvt_pkg::COORD_W-1:0]       in_coord_u,
  input  logic [uvt_pkg::COORD_W-1:0]       in_coord_v,
  output logic                              out_valid,
  output logic [FRAC_BITS:0]                out_wrapped_u,
  output logic [FRAC_BITS:0]                out_wrapped_v,
  input  logic                              cfg_we,
  input  logic [uvt_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [uvt_pkg::CFG_W-1:0]         cfg_wdata
);
  import uvt_pkg::*;

  localparam logic signed [COORD_W:0] HALF = (COORD_W + 1)'(1) << (FRAC_BITS - 1);
  localparam logic [COORD_W-1:0]      ONE  = COORD_W'(1) << FRAC_BITS;
  localparam logic [COORD_W-1:0]      HALF_CFG = COORD_W'(1) << (FRAC_BITS - 1);

  logic                      accept;
  logic signed [COORD_W:0]   cu_r;
  logic signed [COORD_W:0]   cv_r;
  logic [PIPE_DEPTH-1:0]     valid_r;
  axis_cfg_t                 cfg_u_r;
  axis_cfg_t                 cfg_v_r;
  logic [WRAP_W-1:0]         wrap_mode_r;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r     <= '0;
      cfg_u_r     <= '{coef_a: ONE, coef_b: '0, offset: HALF_CFG};
      cfg_v_r     <= '{coef_a: '0, coef_b: ONE, offset: HALF_CFG};
      wrap_mode_r <= WRAP_REPEAT;
    end else begin
      valid_r <= {valid_r[PIPE_DEPTH-2:0], accept};
      if (cfg_we) begin
        case (cfg_index)
          REG_COEF_UU:   cfg_u_r.coef_a <= cfg_wdata;
          REG_COEF_UV:   cfg_u_r.coef_b <= cfg_wdata;
          REG_COEF_VU:   cfg_v_r.coef_a <= cfg_wdata;
          REG_COEF_VV:   cfg_v_r.coef_b <= cfg_wdata;
          REG_OFFSET_U:  cfg_u_r.offset <= cfg_wdata;
          REG_OFFSET_V:  cfg_v_r.offset <= cfg_wdata;
          REG_WRAP_MODE: wrap_mode_r    <= cfg_wdata[WRAP_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cu_r <= $signed({in_coord_u[COORD_W-1], in_coord_u}) - HALF;
      cv_r <= $signed({in_coord_v[COORD_W-1], in_coord_v}) - HALF;
    end
  end

  uvt_axis #(.FRAC_BITS(FRAC_BITS)) u_axis_u (
    .clk       (clk),
    .cu        (cu_r),
    .cv        (cv_r),
    .cfg       (cfg_u_r),
    .wrap_mode (wrap_mode_r),
    .wrapped   (out_wrapped_u)
  );

  uvt_axis #(.FRAC_BITS(FRAC_BITS)) u_axis_v (
    .clk       (clk),
    .cu        (cu_r),
    .cv        (cv_r),
    .cfg       (cfg_v_r),
    .wrap_mode (wrap_mode_r),
    .wrapped   (out_wrapped_v)
  );

  assign out_valid = valid_r[PIPE_DEPTH-1];

endmodule

### rtl/uvt_axis.sv
module uvt_axis #(
  parameter int FRAC_BITS = 16
) (
  input  logic                              clk,
  input  logic signed [uvt_pkg::COORD_W:0]  cu,
  input  logic signed [uvt_pkg::COORD_W:0]  cv,
  input  uvt_pkg::axis_cfg_t                cfg,
  input  logic [uvt_pkg::WRAP_W-1:0]        wrap_mode,
  output logic [FRAC_BITS:0]                wrapped
);
  import uvt_pkg::*;

  localparam int PROD_W = 2 * COORD_W + 1;
  localparam int SUM_W  = PROD_W + 1;
  localparam int FRAC_W = 2 * FRAC_BITS;
  localparam int OFF_PAD = SUM_W - COORD_W - FRAC_BITS;

  logic signed [PROD_W-1:0] prod_a_r;
  logic signed [PROD_W-1:0] prod_b_r;
  logic signed [SUM_W-1:0]  sum_r;
  logic signed [SUM_W-1:0]  sum_nxt;
  logic signed [SUM_W-1:0]  off_ext;
  logic [FRAC_BITS:0]       wrapped_r;
  logic [FRAC_BITS:0]       wrapped_nxt;
  logic                     neg;
  logic                     fneg;
  logic [FRAC_W-1:0]        lo;
  logic [FRAC_W-1:0]        mag;
  logic [FRAC_W:0]          frac_sel;
  logic [FRAC_W:0]          rounded;

  assign off_ext = {{OFF_PAD{cfg.offset[COORD_W-1]}}, cfg.offset, {FRAC_BITS{1'b0}}};
  assign sum_nxt = SUM_W'(prod_a_r) + SUM_W'(prod_b_r) + off_ext;

  always_comb begin
    neg  = sum_r[SUM_W-1];
    lo   = sum_r[FRAC_W-1:0];
    mag  = neg ? (~lo + FRAC_W'(1)) : lo;
    fneg = neg && (mag != '0);
    case (wrap_mode)
      WRAP_REPEAT: frac_sel = {1'b0, lo};
      WRAP_MIRROR: frac_sel = {1'b0, mag};
      default:     frac_sel = fneg ? '0 : {1'b0, mag};
    endcase
    rounded     = frac_sel + ((FRAC_W + 1)'(1) << (FRAC_BITS - 1));
    wrapped_nxt = rounded[FRAC_W:FRAC_BITS];
  end

  always_ff @(posedge clk) begin
    prod_a_r  <= PROD_W'(cu) * PROD_W'(cfg.coef_a);
    prod_b_r  <= PROD_W'(cv) * PROD_W'(cfg.coef_b);
    sum_r     <= sum_nxt;
    wrapped_r <= wrapped_nxt;
  end

  assign wrapped = wrapped_r;

endmodule

### rtl/uvt_checker.sv
`include "assert_macros.svh"

module uvt_checker #(
  parameter int FRAC_BITS = 16
) (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 start,
  input logic                 busy,
  input logic                 out_valid,
  input logic [FRAC_BITS:0]   out_wrapped_u,
  input logic [FRAC_BITS:0]   out_wrapped_v
);
  import uvt_pkg::*;

  localparam logic [FRAC_BITS:0] UNIT = (FRAC_BITS + 1)'(1) << FRAC_BITS;

  `ASSERT_IMPLY(a_never_busy, clk, rst_n, 1'b1, !busy, "busy was raised")
  `ASSERT_IMPLY(a_request_gives_result, clk, rst_n, start && !busy, ##PIPE_DEPTH out_valid, "request produced no result")
  `ASSERT_IMPLY(a_result_has_request, clk, rst_n, out_valid, $past(start && !busy, PIPE_DEPTH), "result without a request")
  `ASSERT_IMPLY(a_result_in_range, clk, rst_n, out_valid, (out_wrapped_u <= UNIT) && (out_wrapped_v <= UNIT), "result above one")

endmodule

bind uv_transform_wrap uvt_checker #(.FRAC_BITS(FRAC_BITS)) u_uvt_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .start         (start),
  .busy          (busy),
  .out_valid     (out_valid),
  .out_wrapped_u (out_wrapped_u),
  .out_wrapped_v (out_wrapped_v)
);

### tb/sv/uv_transform_wrap_test.sv
`timescale 1ns / 1ps

module uv_transform_wrap_test;
  import uvt_pkg::*;

  localparam int FRAC_BITS = 16;
  localparam int QUIET_LIMIT = 2000;
  localparam int PHASE_ITEMS = 140;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
  localparam logic [WRAP_W-1:0] WRAP_SPARE = 2'd3;

  typedef struct packed {
    logic [FRAC_BITS:0] u;
    logic [FRAC_BITS:0] v;
  } uv_pair_t;

  logic clk = 1'b0;
  logic rst_n;
  logic start;
  logic busy;
  logic [COORD_W-1:0] in_coord_u;
  logic [COORD_W-1:0] in_coord_v;
  logic out_valid;
  logic [FRAC_BITS:0] out_wrapped_u;
  logic [FRAC_BITS:0] out_wrapped_v;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0] cfg_wdata;

  // Shadow copy of the transform registers, at their reset values.
  logic [CFG_W-1:0] mat_uu = CFG_W'(1 << FRAC_BITS);
  logic [CFG_W-1:0] mat_uv = '0;
  logic [CFG_W-1:0] mat_vu = '0;
  logic [CFG_W-1:0] mat_vv = CFG_W'(1 << FRAC_BITS);
  logic [CFG_W-1:0] ofs_u = CFG_W'(1 << (FRAC_BITS - 1));
  logic [CFG_W-1:0] ofs_v = CFG_W'(1 << (FRAC_BITS - 1));
  logic [WRAP_W-1:0] wrap_sel = WRAP_REPEAT;

  uv_pair_t uv_pending[$];
  int mismatch_count = 0;
  int quiet_cycles = 0;
  bit idle_on = 1'b1;

  uv_transform_wrap #(.FRAC_BITS(FRAC_BITS)) dut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_coord_u(in_coord_u),
    .in_coord_v(in_coord_v),
    .out_valid(out_valid),
    .out_wrapped_u(out_wrapped_u),
    .out_wrapped_v(out_wrapped_v),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic logic [FRAC_BITS:0] fold_axis(input longint cu, input longint cv,
      input logic [CFG_W-1:0] wa, input logic [CFG_W-1:0] wb, input logic [CFG_W-1:0] off);
    logic signed [67:0] t0;
    logic signed [67:0] t1;
    logic signed [67:0] t2;
    logic signed [67:0] sum;
    logic [67:0] mag;
    logic [2*FRAC_BITS-1:0] frac;
    logic [2*FRAC_BITS+1:0] r;
    logic fneg;
    t0 = cu * longint'($signed(wa));
    t1 = cv * longint'($signed(wb));
    t2 = longint'($signed(off)) <<< FRAC_BITS;
    sum = t0 + t1 + t2;
    mag = sum[67] ? -sum : sum;
    frac = mag[2*FRAC_BITS-1:0];
    fneg = sum[67] && (frac != '0);
    case (wrap_sel)
      WRAP_REPEAT: begin
        r = fneg ? ((2*FRAC_BITS+2)'(1) << (2*FRAC_BITS)) - frac : frac;
      end
      WRAP_MIRROR: begin
        r = frac;
      end
      default: begin
        r = fneg ? '0 : frac;
      end
    endcase
    r = r + ((2*FRAC_BITS+2)'(1) << (FRAC_BITS - 1));
    return (FRAC_BITS+1)'(r >> FRAC_BITS);
  endfunction

  function automatic uv_pair_t predict_uv(input logic [COORD_W-1:0] u,
                                          input logic [COORD_W-1:0] v);
    uv_pair_t res;
    longint cu;
    longint cv;
    cu = longint'($signed(u)) - (longint'(1) << (FRAC_BITS - 1));
    cv = longint'($signed(v)) - (longint'(1) << (FRAC_BITS - 1));
    res.u = fold_axis(cu, cv, mat_uu, mat_uv, ofs_u);
    res.v = fold_axis(cu, cv, mat_vu, mat_vv, ofs_v);
    return res;
  endfunction

  function automatic logic [CFG_W-1:0] pick_coef();
    case ($urandom_range(7))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return '0;
      3, 4: return $urandom;
      default: return CFG_W'($urandom_range(0, 1 << 19)) - CFG_W'(1 << 18);
    endcase
  endfunction

  function automatic logic [COORD_W-1:0] pick_coord();
    case ($urandom_range(9))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2, 3: return $urandom;
      default: return COORD_W'($urandom_range(0, 1 << 20)) - COORD_W'(1 << 19);
    endcase
  endfunction

  task automatic send_coord(input logic [COORD_W-1:0] u, input logic [COORD_W-1:0] v);
    while (idle_on && $urandom_range(99) < 37) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    in_coord_u <= u;
    in_coord_v <= v;
    do @(posedge clk); while (busy);
    uv_pending.push_back(predict_uv(u, v));
  endtask

  task automatic drain_results();
    start <= 1'b0;
    @(posedge clk);
    while (uv_pending.size() != 0) @(posedge clk);
  endtask

  // Leaves the write enable high so that writes can follow back to back.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    case (idx)
      REG_COEF_UU: mat_uu = val;
      REG_COEF_UV: mat_uv = val;
      REG_COEF_VU: mat_vu = val;
      REG_COEF_VV: mat_vv = val;
      REG_OFFSET_U: ofs_u = val;
      REG_OFFSET_V: ofs_v = val;
      REG_WRAP_MODE: wrap_sel = val[WRAP_W-1:0];
      default: ;
    endcase
  endtask

  task automatic close_writes();
    cfg_we <= 1'b0;
  endtask

  task automatic test_reset_defaults();
    send_coord(32'h0000_0000, 32'h0000_0000);
    send_coord(32'h7FFF_FFFF, 32'h8000_0000);
    send_coord(32'h0001_0000, 32'h0000_8000);
    send_coord(32'hFFFF_0000, 32'hFFFF_FFFF);
    send_coord(32'h0001_8000, 32'hFFFE_8000);
  endtask

  task automatic test_wrap_modes();
    logic [WRAP_W-1:0] modes [4];
    modes = '{WRAP_MIRROR, WRAP_CLAMP, WRAP_SPARE, WRAP_REPEAT};
    foreach (modes[m]) begin
      drain_results();
      write_reg(REG_WRAP_MODE, {30'($urandom), modes[m]});
      write_reg(REG_UNUSED, $urandom);
      close_writes();
      send_coord(32'hFFFF_4000, 32'h0001_4000);
      send_coord(32'hFFFF_0000, 32'h0001_0000);
    end
  endtask

  task automatic test_coef_extremes();
    drain_results();
    write_reg(REG_COEF_UU, 32'h8000_0000);
    write_reg(REG_COEF_UV, 32'h7FFF_FFFF);
    write_reg(REG_COEF_VU, 32'h7FFF_FFFF);
    write_reg(REG_COEF_VV, 32'h8000_0000);
    write_reg(REG_OFFSET_U, 32'h8000_0000);
    write_reg(REG_OFFSET_V, 32'h7FFF_FFFF);
    write_reg(REG_WRAP_MODE, {30'd0, WRAP_MIRROR});
    close_writes();
    send_coord(32'h8000_0000, 32'h8000_0000);
    send_coord(32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_coord(32'h8000_0000, 32'h7FFF_FFFF);
    // With the smallest weights a tiny negative sum under repeat rounds up to one.
    drain_results();
    write_reg(REG_COEF_UU, 32'h0000_0001);
    write_reg(REG_COEF_UV, 32'h0000_0000);
    write_reg(REG_COEF_VU, 32'h0000_0000);
    write_reg(REG_COEF_VV, 32'hFFFF_FFFF);
    write_reg(REG_OFFSET_U, 32'h0000_0000);
    write_reg(REG_OFFSET_V, 32'h0000_0000);
    write_reg(REG_WRAP_MODE, {30'd0, WRAP_REPEAT});
    close_writes();
    send_coord(32'h0000_7FFF, 32'h0000_7FFF);
    send_coord(32'h0000_8001, 32'h0000_8001);
  endtask

  task automatic test_random_traffic();
    logic [WRAP_W-1:0] modes [4];
    modes = '{WRAP_REPEAT, WRAP_MIRROR, WRAP_CLAMP, WRAP_SPARE};
    for (int p = 0; p < 10; p++) begin
      drain_results();
      write_reg(REG_COEF_UU, pick_coef());
      write_reg(REG_COEF_UV, pick_coef());
      write_reg(REG_COEF_VU, pick_coef());
      write_reg(REG_COEF_VV, pick_coef());
      write_reg(REG_OFFSET_U, pick_coef());
      write_reg(REG_OFFSET_V, pick_coef());
      write_reg(REG_WRAP_MODE, {30'($urandom), modes[p % 4]});
      close_writes();
      idle_on = (p != 3);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (p == 5 && i == PHASE_ITEMS / 2) begin
          drain_results();
        end
        send_coord(pick_coord(), pick_coord());
      end
    end
    idle_on = 1'b1;
  endtask

  always @(posedge clk) begin : check_results
    uv_pair_t want;
    if (rst_n && out_valid) begin
      if (uv_pending.size() == 0) begin
        $error("Result with no request outstanding: wrapped_u %0d wrapped_v %0d",
               out_wrapped_u, out_wrapped_v);
        mismatch_count++;
      end else begin
        want = uv_pending.pop_front();
        if (out_wrapped_u !== want.u) begin
          $error("wrapped_u: expected %0d, got %0d", want.u, out_wrapped_u);
          mismatch_count++;
        end
        if (out_wrapped_v !== want.v) begin
          $error("wrapped_v: expected %0d, got %0d", want.v, out_wrapped_v);
          mismatch_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((start && !busy) || out_valid) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst_n <= 1'b0;
    start <= 1'b0;
    in_coord_u <= '0;
    in_coord_v <= '0;
    cfg_we <= 1'b0;
    cfg_index <= '0;
    cfg_wdata <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_defaults();
    test_wrap_modes();
    test_coef_extremes();
    test_random_traffic();
    drain_results();
    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

### uv_transform_wrap.f
+incdir+rtl
rtl/uvt_pkg.sv
rtl/uvt_axis.sv
rtl/uv_transform_wrap.sv
rtl/uvt_checker.sv
tb/sv/uv_transform_wrap_test.sv
